// ===== design/llpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llpp_pkg
// Shared widths, types and register codes for the lidar point projection core.
// ----------------------------------------------------------------------------
package llpp_pkg;

  localparam int POINT_BITS = 16;
  localparam int PIXEL_BITS = 12;
  localparam int COEF_BITS  = 16;
  localparam int PARAM_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int TRANS_BITS = 16;

  localparam int PROD_BITS = POINT_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int CAM_BITS  = ACC_BITS - FRAC_BITS + 1;
  localparam int MUL_BITS  = CAM_BITS + PARAM_BITS + 1;
  localparam int NUM_BITS  = MUL_BITS + 1;
  localparam int DEN_BITS  = CAM_BITS + 4;

  localparam int ROT_BITS  = 3 * COEF_BITS;
  localparam int XLAT_BITS = 3 * TRANS_BITS;
  localparam int PAIR_BITS = 2 * PARAM_BITS;
  localparam int SIZE_BITS = 2 * PIXEL_BITS;
  localparam int DATA_BITS = 48;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR   = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 32;
  localparam int RQ_PTR   = $clog2(RQ_DEPTH);
  localparam int RQ_CNT   = RQ_PTR + 1;

  typedef enum logic [2:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_XLAT   = 3'd3,
    REG_FOCAL  = 3'd4,
    REG_CENTER = 3'd5,
    REG_SIZE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [POINT_BITS-1:0] x;
    logic signed [POINT_BITS-1:0] y;
    logic signed [POINT_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic [ROT_BITS-1:0]  rot0;
    logic [ROT_BITS-1:0]  rot1;
    logic [ROT_BITS-1:0]  rot2;
    logic [XLAT_BITS-1:0] xlat;
    logic [PAIR_BITS-1:0] focal;
    logic [PAIR_BITS-1:0] center;
    logic [SIZE_BITS-1:0] size;
  } cfg_t;

  typedef struct packed {
    point_t                      pt;
    logic signed [NUM_BITS-1:0]  num_x;
    logic signed [NUM_BITS-1:0]  num_y;
    logic signed [CAM_BITS-1:0]  cam_z;
  } xform_t;

  typedef struct packed {
    point_t                pt;
    logic                  zero;
    logic                  neg_x;
    logic                  neg_y;
    logic                  ovf_x;
    logic                  ovf_y;
    logic [DEN_BITS-1:0]   absd;
  } div_ctx_t;

  typedef struct packed {
    logic                  in_image;
    logic [PIXEL_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] row;
    point_t                pt;
  } result_t;

endpackage
`default_nettype wire

// ===== design/llpp_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llpp_cmd_queue
// Front queue: takes points from the input side and hands them to the pipeline.
// ----------------------------------------------------------------------------
module llpp_cmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire llpp_pkg::point_t push_pt,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output llpp_pkg::point_t     head
);
  import llpp_pkg::*;

  point_t            mem [CQ_DEPTH];
  logic [CQ_PTR-1:0] wr_ptr;
  logic [CQ_PTR-1:0] rd_ptr;
  logic [CQ_PTR:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (CQ_PTR+1)'(CQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/llpp_transform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llpp_transform
// Rigid transform and pixel numerators, four register stages.
// ----------------------------------------------------------------------------
module llpp_transform (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire llpp_pkg::point_t in_pt,
  input  wire llpp_pkg::cfg_t   cfg,
  output logic                  out_valid,
  output llpp_pkg::xform_t      out
);
  import llpp_pkg::*;

  logic                        v1, v2, v3;
  point_t                      pt1, pt2, pt3;
  logic signed [PROD_BITS-1:0] prod [3][3];
  logic signed [CAM_BITS-1:0]  cam  [3];
  logic signed [CAM_BITS-1:0]  cam_next [3];
  logic signed [MUL_BITS-1:0]  fx_term, fy_term, cx_term, cy_term;
  logic signed [CAM_BITS-1:0]  cz3;
  logic signed [COEF_BITS-1:0] coef [3][3];
  logic signed [POINT_BITS-1:0] pv [3];
  logic [ROT_BITS-1:0]         rows [3];

  assign rows[0] = cfg.rot0;
  assign rows[1] = cfg.rot1;
  assign rows[2] = cfg.rot2;
  assign pv[0]   = in_pt.x;
  assign pv[1]   = in_pt.y;
  assign pv[2]   = in_pt.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k] = rows[i][k*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod[i][k] <= coef[i][k] * pv[k];
      end
    end
    pt1 <= in_pt;
  end

  // stage 2: sum, round off the Q.14 coefficient fraction, add translation
  always_comb begin
    logic signed [ACC_BITS-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = ACC_BITS'(prod[i][0]) + ACC_BITS'(prod[i][1]) + ACC_BITS'(prod[i][2])
            + ACC_BITS'(1 << (FRAC_BITS-1));
      cam_next[i] = CAM_BITS'(acc >>> FRAC_BITS)
                    + CAM_BITS'($signed(cfg.xlat[i*TRANS_BITS +: TRANS_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) cam[i] <= cam_next[i];
    pt2 <= pt1;
  end

  // stage 3: focal and center products
  always_ff @(posedge clk) begin
    fx_term <= cam[0] * $signed({1'b0, cfg.focal[0 +: PARAM_BITS]});
    fy_term <= cam[1] * $signed({1'b0, cfg.focal[PARAM_BITS +: PARAM_BITS]});
    cx_term <= cam[2] * $signed({1'b0, cfg.center[0 +: PARAM_BITS]});
    cy_term <= cam[2] * $signed({1'b0, cfg.center[PARAM_BITS +: PARAM_BITS]});
    cz3     <= cam[2];
    pt3     <= pt2;
  end

  // stage 4: numerators
  always_ff @(posedge clk) begin
    out.num_x <= NUM_BITS'(fx_term) + NUM_BITS'(cx_term);
    out.num_y <= NUM_BITS'(fy_term) + NUM_BITS'(cy_term);
    out.cam_z <= cz3;
    out.pt    <= pt3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule
`default_nettype wire

// ===== design/llpp_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llpp_divider
// Pipelined restoring divide of both numerators by 16*cam_z, then image test.
// ----------------------------------------------------------------------------
module llpp_divider (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire llpp_pkg::xform_t in,
  input  wire llpp_pkg::cfg_t   cfg,
  output logic                  out_valid,
  output llpp_pkg::result_t     out
);
  import llpp_pkg::*;

  logic                  va, vs [PIXEL_BITS+1];
  point_t                pta;
  logic                  zero_a, negx_a, negy_a;
  logic [NUM_BITS-1:0]   absx_a, absy_a;
  logic [DEN_BITS-1:0]   absd_a;
  logic [CAM_BITS-1:0]   abs_cz;

  div_ctx_t              ctx  [PIXEL_BITS+1];
  logic [NUM_BITS-1:0]   remx [PIXEL_BITS+1];
  logic [NUM_BITS-1:0]   remy [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] qx   [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] qy   [PIXEL_BITS+1];
  logic [NUM_BITS-1:0]   dtop;

  assign abs_cz = in.cam_z[CAM_BITS-1] ? CAM_BITS'(-in.cam_z) : CAM_BITS'(in.cam_z);

  // take magnitudes and signs
  always_ff @(posedge clk) begin
    absx_a <= in.num_x[NUM_BITS-1] ? NUM_BITS'(-in.num_x) : NUM_BITS'(in.num_x);
    absy_a <= in.num_y[NUM_BITS-1] ? NUM_BITS'(-in.num_y) : NUM_BITS'(in.num_y);
    negx_a <= in.num_x[NUM_BITS-1] ^ in.cam_z[CAM_BITS-1];
    negy_a <= in.num_y[NUM_BITS-1] ^ in.cam_z[CAM_BITS-1];
    zero_a <= (in.cam_z == '0);
    absd_a <= {abs_cz, 4'b0};
    pta    <= in.pt;
  end

  // flag quotients too large for a pixel index
  assign dtop = NUM_BITS'(absd_a) << PIXEL_BITS;

  always_ff @(posedge clk) begin
    ctx[0].pt    <= pta;
    ctx[0].zero  <= zero_a;
    ctx[0].neg_x <= negx_a;
    ctx[0].neg_y <= negy_a;
    ctx[0].ovf_x <= (absx_a >= dtop);
    ctx[0].ovf_y <= (absy_a >= dtop);
    ctx[0].absd  <= absd_a;
    remx[0]      <= absx_a;
    remy[0]      <= absy_a;
    qx[0]        <= '0;
    qy[0]        <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_step
    logic [NUM_BITS-1:0] dsh;
    assign dsh = NUM_BITS'(ctx[k].absd) << (PIXEL_BITS-1-k);
    always_ff @(posedge clk) begin
      ctx[k+1] <= ctx[k];
      if (remx[k] >= dsh) begin
        remx[k+1] <= remx[k] - dsh;
        qx[k+1]   <= qx[k] | PIXEL_BITS'(1 << (PIXEL_BITS-1-k));
      end else begin
        remx[k+1] <= remx[k];
        qx[k+1]   <= qx[k];
      end
      if (remy[k] >= dsh) begin
        remy[k+1] <= remy[k] - dsh;
        qy[k+1]   <= qy[k] | PIXEL_BITS'(1 << (PIXEL_BITS-1-k));
      end else begin
        remy[k+1] <= remy[k];
        qy[k+1]   <= qy[k];
      end
    end
  end

  // image test and result
  always_ff @(posedge clk) begin
    logic ok_x, ok_y, hit;
    ok_x   = !ctx[PIXEL_BITS].ovf_x && !(ctx[PIXEL_BITS].neg_x && qx[PIXEL_BITS] != '0)
             && (qx[PIXEL_BITS] < cfg.size[0 +: PIXEL_BITS]);
    ok_y   = !ctx[PIXEL_BITS].ovf_y && !(ctx[PIXEL_BITS].neg_y && qy[PIXEL_BITS] != '0)
             && (qy[PIXEL_BITS] < cfg.size[PIXEL_BITS +: PIXEL_BITS]);
    hit    = !ctx[PIXEL_BITS].zero && ok_x && ok_y;
    out.in_image <= hit;
    out.col      <= hit ? qx[PIXEL_BITS] : '0;
    out.row      <= hit ? qy[PIXEL_BITS] : '0;
    out.pt       <= ctx[PIXEL_BITS].pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      for (int i = 0; i <= PIXEL_BITS; i++) vs[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va    <= in_valid;
      vs[0] <= va;
      for (int i = 0; i < PIXEL_BITS; i++) vs[i+1] <= vs[i];
      out_valid <= vs[PIXEL_BITS];
    end
  end

endmodule
`default_nettype wire

// ===== design/llpp_result_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llpp_result_queue
// Back queue: holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module llpp_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire llpp_pkg::result_t push_res,
  input  wire logic              pop,
  output logic                   empty,
  output llpp_pkg::result_t      head,
  output logic [llpp_pkg::RQ_CNT-1:0] count
);
  import llpp_pkg::*;

  result_t           mem [RQ_DEPTH];
  logic [RQ_PTR-1:0] wr_ptr;
  logic [RQ_PTR-1:0] rd_ptr;
  logic              do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/lidar_point_pixel_projection_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_pixel_projection_core
// Moves lidar points into the camera frame and projects them to pixels.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  points   | push / full          | point_x, point_y, point_z
//  results  | pop / empty          | in_image, pixel_col, pixel_row, out_x..out_z
//  config   | cfg_we               | cfg_index, cfg_data
//
// One point per clock while the result queue has room; a point's path after it
// leaves the front queue runs through 4 transform stages and 15 divider stages
// (magnitudes, setup, 12 quotient-bit stages and the image test), then a write
// into the result queue. Reset clears queues, pipeline valids and loads the
// identity rotation. A stalled consumer fills the 32-beat result queue; issue
// from the front queue holds once in-flight beats plus queued results reach it.
// ----------------------------------------------------------------------------
module lidar_point_pixel_projection_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [llpp_pkg::POINT_BITS-1:0] point_x,
  input  wire logic signed [llpp_pkg::POINT_BITS-1:0] point_y,
  input  wire logic signed [llpp_pkg::POINT_BITS-1:0] point_z,
  input  wire logic                                pop,
  output logic                                     empty,
  output logic                                     in_image,
  output logic [llpp_pkg::PIXEL_BITS-1:0]          pixel_col,
  output logic [llpp_pkg::PIXEL_BITS-1:0]          pixel_row,
  output logic signed [llpp_pkg::POINT_BITS-1:0]   out_x,
  output logic signed [llpp_pkg::POINT_BITS-1:0]   out_y,
  output logic signed [llpp_pkg::POINT_BITS-1:0]   out_z,
  input  wire logic                                cfg_we,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [llpp_pkg::DATA_BITS-1:0]      cfg_data
);
  import llpp_pkg::*;

  cfg_t            cfg;
  point_t          in_pt;
  point_t          cq_head;
  logic            cq_empty;
  logic            issue;
  logic            xf_valid;
  xform_t          xf_out;
  logic            dv_valid;
  result_t         dv_out;
  result_t         rq_head;
  logic [RQ_CNT-1:0] rq_count;
  logic [RQ_CNT-1:0] inflight;
  logic [RQ_CNT:0]   credit_used;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot0   <= ROT_BITS'(1 << FRAC_BITS);
      cfg.rot1   <= ROT_BITS'(1 << FRAC_BITS) << COEF_BITS;
      cfg.rot2   <= ROT_BITS'(1 << FRAC_BITS) << (2*COEF_BITS);
      cfg.xlat   <= '0;
      cfg.focal  <= '0;
      cfg.center <= '0;
      cfg.size   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROT0:   cfg.rot0   <= cfg_data[ROT_BITS-1:0];
        REG_ROT1:   cfg.rot1   <= cfg_data[ROT_BITS-1:0];
        REG_ROT2:   cfg.rot2   <= cfg_data[ROT_BITS-1:0];
        REG_XLAT:   cfg.xlat   <= cfg_data[XLAT_BITS-1:0];
        REG_FOCAL:  cfg.focal  <= cfg_data[PAIR_BITS-1:0];
        REG_CENTER: cfg.center <= cfg_data[PAIR_BITS-1:0];
        REG_SIZE:   cfg.size   <= cfg_data[SIZE_BITS-1:0];
        default:    ;
      endcase
    end
  end

  assign in_pt.x = point_x;
  assign in_pt.y = point_y;
  assign in_pt.z = point_z;

  llpp_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_pt (in_pt),
    .full    (full),
    .pop     (issue),
    .empty   (cq_empty),
    .head    (cq_head)
  );

  // issue only when the result queue is sure to have room for every beat in flight
  assign credit_used = (RQ_CNT+1)'(inflight) + (RQ_CNT+1)'(rq_count);
  assign issue       = !cq_empty && (credit_used < (RQ_CNT+1)'(RQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (issue && !dv_valid) begin
      inflight <= inflight + 1'b1;
    end else if (dv_valid && !issue) begin
      inflight <= inflight - 1'b1;
    end
  end

  llpp_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .in_pt     (cq_head),
    .cfg       (cfg),
    .out_valid (xf_valid),
    .out       (xf_out)
  );

  llpp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in        (xf_out),
    .cfg       (cfg),
    .out_valid (dv_valid),
    .out       (dv_out)
  );

  llpp_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (dv_valid),
    .push_res (dv_out),
    .pop      (pop),
    .empty    (empty),
    .head     (rq_head),
    .count    (rq_count)
  );

  assign in_image  = rq_head.in_image;
  assign pixel_col = rq_head.col;
  assign pixel_row = rq_head.row;
  assign out_x     = rq_head.pt.x;
  assign out_y     = rq_head.pt.y;
  assign out_z     = rq_head.pt.z;

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    dv_valid |-> (rq_count < RQ_CNT'(RQ_DEPTH)))
    else $error("result queue written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= (RQ_CNT+1)'(RQ_DEPTH))
    else $error("in-flight beats exceed result queue room");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && in_image) |-> (pixel_col < cfg.size[0 +: PIXEL_BITS]
                              && pixel_row < cfg.size[PIXEL_BITS +: PIXEL_BITS]))
    else $error("pixel outside image flagged inside");

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    (!empty && !in_image) |-> (pixel_col == '0 && pixel_row == '0))
    else $error("pixel not cleared for point outside image");
`endif

endmodule
`default_nettype wire
